// ----- src/tgd_pkg.sv -----
// Package for the tile id frame decoder: payload structs, status codes,
// command and register index constants. No dependencies.
`timescale 1ns / 1ps

package tgd_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NO_SET   = 3'd2,
    ST_BAD_GEOM = 3'd3,
    ST_LOADED   = 3'd4
  } status_t;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  localparam int  CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_TW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_TH = 1'b1;

  localparam logic [31:0] FLAG_H   = 32'h8000_0000;
  localparam logic [31:0] FLAG_V   = 32'h4000_0000;
  localparam logic [31:0] FLAG_D   = 32'h2000_0000;
  localparam logic [31:0] GID_MASK = 32'h1FFF_FFFF;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  entry_index;
    logic [28:0] first_gid;
    logic [9:0]  set_tile_width;
    logic [9:0]  set_tile_height;
    logic [12:0] set_image_width;
    logic [31:0] raw_gid;
    logic [11:0] column;
    logic [11:0] row;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [1:0]         tileset_slot;
    logic [12:0]        src_x;
    logic [15:0]        src_y;
    logic [9:0]         frame_width;
    logic [9:0]         frame_height;
    logic [21:0]        render_x;
    logic signed [23:0] render_y;
    logic               flip_h;
    logic               flip_v;
    logic               flip_d;
  } out_item_t;

  // Result fields that travel alongside the divider stages.
  typedef struct packed {
    status_t            status;
    logic [1:0]         slot;
    logic [9:0]         tw;
    logic [9:0]         th;
    logic [21:0]        render_x;
    logic signed [23:0] render_y;
    logic               flip_h;
    logic               flip_v;
    logic               flip_d;
  } side_t;

endpackage

// ----- src/tgd_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per register stage, with a
// sideband word carried along. Standalone; no package dependency.
`timescale 1ns / 1ps

module tgd_div_pipe #(
  parameter int DW = 13,
  parameter int VW = 10,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [DW-1:0] in_dividend,
  input  logic [VW-1:0] in_divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [DW-1:0] out_quo,
  output logic [VW-1:0] out_rem,
  output logic [SW-1:0] out_side
);

  logic          vld_r [0:DW-1];
  logic [VW-1:0] rem_r [0:DW-1];
  logic [DW-1:0] quo_r [0:DW-1];
  logic [VW-1:0] dv_r  [0:DW-1];
  logic [SW-1:0] sd_r  [0:DW-1];

  for (genvar k = 0; k < DW; k++) begin : g_st
    logic          vld_i;
    logic [VW-1:0] rem_i;
    logic [DW-1:0] quo_i;
    logic [VW-1:0] dv_i;
    logic [SW-1:0] sd_i;
    logic [VW:0]   trial;
    logic [VW-1:0] rem_nxt;
    logic [DW-1:0] quo_nxt;

    if (k == 0) begin : g_head
      assign vld_i = in_vld;
      assign rem_i = '0;
      assign quo_i = in_dividend;
      assign dv_i  = in_divisor;
      assign sd_i  = in_side;
    end else begin : g_body
      assign vld_i = vld_r[k-1];
      assign rem_i = rem_r[k-1];
      assign quo_i = quo_r[k-1];
      assign dv_i  = dv_r[k-1];
      assign sd_i  = sd_r[k-1];
    end

    always_comb begin
      trial = {rem_i, quo_i[DW-1]};
      if (trial >= {1'b0, dv_i}) begin
        rem_nxt = VW'(trial - {1'b0, dv_i});
        quo_nxt = {quo_i[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[VW-1:0];
        quo_nxt = {quo_i[DW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_i;
      end
      rem_r[k] <= rem_nxt;
      quo_r[k] <= quo_nxt;
      dv_r[k]  <= dv_i;
      sd_r[k]  <= sd_i;
    end
  end

  assign out_vld  = vld_r[DW-1];
  assign out_quo  = quo_r[DW-1];
  assign out_rem  = rem_r[DW-1];
  assign out_side = sd_r[DW-1];

endmodule

// ----- src/tile_gid_frame_decoder_unit.sv -----
// Top level of the tile id frame decoder: tileset table, lookup, render
// math and two divider pipelines. Uses tgd_pkg and tgd_div_pipe.
//
// Channel  | Ports                                | Transfer
// input    | start, busy, in_data                 | start high and busy low
// result   | out_valid, out_data                  | every cycle out_valid is high
// config   | cfg_we, cfg_index, cfg_wdata         | every cycle cfg_we is high
//
// One item enters per cycle; busy stays low. A result passes the input, lookup
// and render registers, then the two bit-serial divider pipelines (13 and 29
// stages), then the multiply and output registers.
// Loads update the table at the lookup stage, so later decodes see them.
// Reset is synchronous and clears valid bits, the table valid bits and the
// map tile size registers (to 32). The receiver cannot stall.
`timescale 1ns / 1ps

module tile_gid_frame_decoder_unit #(
  parameter int NUM_TILESETS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  tgd_pkg::in_item_t             in_data,
  output logic                          out_valid,
  output tgd_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [tgd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [9:0]                    cfg_wdata
);

  localparam int SIDE_W = $bits(tgd_pkg::side_t);

  logic [9:0] map_tw_r, map_th_r;

  logic               in_vld_r;
  tgd_pkg::in_item_t  in_r;

  logic        ent_vld_r [0:NUM_TILESETS-1];
  logic [28:0] ent_gid_r [0:NUM_TILESETS-1];
  logic [9:0]  ent_tw_r  [0:NUM_TILESETS-1];
  logic [9:0]  ent_th_r  [0:NUM_TILESETS-1];
  logic [12:0] ent_iw_r  [0:NUM_TILESETS-1];

  tgd_pkg::side_t s1_side_nxt;
  logic [28:0]    s1_idx_nxt;
  logic [12:0]    s1_iw_nxt;
  logic [21:0]    s1_rowp_nxt;
  logic [28:0]    gid;
  logic           hit;
  logic [28:0]    sel_first;

  logic           s1_vld_r;
  tgd_pkg::side_t s1_side_r;
  logic [28:0]    s1_idx_r;
  logic [12:0]    s1_iw_r;
  logic [21:0]    s1_rowp_r;

  logic           s2_vld_r;
  tgd_pkg::side_t s2_side_r;
  logic [28:0]    s2_idx_r;
  logic [12:0]    s2_iw_r;
  tgd_pkg::side_t s2_side_nxt;

  logic                 da_vld;
  logic [12:0]          da_quo;
  logic [9:0]           da_rem;
  logic [SIDE_W+28:0]   da_side;
  tgd_pkg::side_t       da_sd;
  tgd_pkg::side_t       db_in_sd;

  logic           db_vld;
  logic [28:0]    db_quo;
  logic [12:0]    db_rem;
  logic [SIDE_W-1:0] db_side;
  tgd_pkg::side_t db_sd;

  logic [22:0]    sx_prod;
  logic [38:0]    sy_prod;
  logic           m_vld_r;
  tgd_pkg::side_t m_side_r;
  logic [12:0]    m_sx_r;
  logic [15:0]    m_sy_r;

  logic               out_valid_r;
  tgd_pkg::out_item_t out_data_r;

  assign busy = 1'b0;

  // Configuration and input registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_tw_r <= 10'd32;
      map_th_r <= 10'd32;
      in_vld_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == tgd_pkg::CFG_MAP_TW) begin
        map_tw_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == tgd_pkg::CFG_MAP_TH) begin
        map_th_r <= cfg_wdata;
      end
      in_vld_r <= start && !busy;
    end
    in_r <= in_data;
  end

  // Tileset table; a load lands at the same stage where decodes look up.
  for (genvar i = 0; i < NUM_TILESETS; i++) begin : g_ent
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ent_vld_r[i] <= 1'b0;
      end else if (in_vld_r && in_r.cmd == tgd_pkg::CMD_LOAD &&
                   32'(in_r.entry_index) == i) begin
        ent_vld_r[i] <= 1'b1;
      end
      if (in_vld_r && in_r.cmd == tgd_pkg::CMD_LOAD && 32'(in_r.entry_index) == i) begin
        ent_gid_r[i] <= in_r.first_gid;
        ent_tw_r[i]  <= in_r.set_tile_width;
        ent_th_r[i]  <= in_r.set_tile_height;
        ent_iw_r[i]  <= in_r.set_image_width;
      end
    end
  end

  // Lookup stage: the highest valid entry whose first id is not above the id wins.
  always_comb begin
    gid         = in_r.raw_gid[28:0];
    hit         = 1'b0;
    sel_first   = '0;
    s1_side_nxt = '0;
    s1_idx_nxt  = '0;
    s1_iw_nxt   = '0;
    s1_rowp_nxt = '0;
    for (int i = 0; i < NUM_TILESETS; i++) begin
      if (ent_vld_r[i] && gid >= ent_gid_r[i]) begin
        hit                = 1'b1;
        sel_first          = ent_gid_r[i];
        s1_side_nxt.slot   = 2'(i);
        s1_side_nxt.tw     = ent_tw_r[i];
        s1_side_nxt.th     = ent_th_r[i];
        s1_iw_nxt          = ent_iw_r[i];
      end
    end
    if (in_r.cmd == tgd_pkg::CMD_LOAD) begin
      s1_side_nxt        = '0;
      s1_iw_nxt          = '0;
      s1_side_nxt.status = tgd_pkg::ST_LOADED;
      s1_side_nxt.slot   = in_r.entry_index;
    end else if (in_r.raw_gid == 32'd0) begin
      s1_side_nxt        = '0;
      s1_iw_nxt          = '0;
      s1_side_nxt.status = tgd_pkg::ST_EMPTY;
    end else begin
      s1_side_nxt.flip_h = |(in_r.raw_gid & tgd_pkg::FLAG_H);
      s1_side_nxt.flip_v = |(in_r.raw_gid & tgd_pkg::FLAG_V);
      s1_side_nxt.flip_d = |(in_r.raw_gid & tgd_pkg::FLAG_D);
      if (hit) begin
        s1_side_nxt.status   = tgd_pkg::ST_OK;
        s1_side_nxt.render_x = 22'(in_r.column * map_tw_r);
        s1_rowp_nxt          = 22'(in_r.row * map_th_r);
        s1_idx_nxt           = gid - sel_first;
      end else begin
        s1_side_nxt.status = tgd_pkg::ST_NO_SET;
        s1_side_nxt.slot   = '0;
        s1_side_nxt.tw     = '0;
        s1_side_nxt.th     = '0;
        s1_iw_nxt          = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld_r;
      s2_vld_r <= s1_vld_r;
    end
    s1_side_r <= s1_side_nxt;
    s1_idx_r  <= s1_idx_nxt;
    s1_iw_r   <= s1_iw_nxt;
    s1_rowp_r <= s1_rowp_nxt;
    s2_side_r <= s2_side_nxt;
    s2_idx_r  <= s1_idx_r;
    s2_iw_r   <= s1_iw_r;
  end

  // Render row offset: the cell's bottom edge minus the frame height.
  always_comb begin
    s2_side_nxt = s1_side_r;
    if (s1_side_r.status == tgd_pkg::ST_OK) begin
      s2_side_nxt.render_y = signed'({2'b00, s1_rowp_r} + {14'd0, map_th_r}
                                     - {14'd0, s1_side_r.th});
    end
  end

  // Tiles per row.
  tgd_div_pipe #(.DW(13), .VW(10), .SW(SIDE_W + 29)) u_div_tpr (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (s2_vld_r),
    .in_dividend (s2_iw_r),
    .in_divisor  (s2_side_r.tw),
    .in_side     ({s2_side_r, s2_idx_r}),
    .out_vld     (da_vld),
    .out_quo     (da_quo),
    .out_rem     (da_rem),
    .out_side    (da_side)
  );

  always_comb begin
    da_sd    = tgd_pkg::side_t'(da_side[SIDE_W+28:29]);
    db_in_sd = da_sd;
    if (da_sd.status == tgd_pkg::ST_OK &&
        (da_sd.tw == 10'd0 || da_sd.th == 10'd0 || da_quo == 13'd0)) begin
      db_in_sd.status = tgd_pkg::ST_BAD_GEOM;
    end
  end

  // Frame row and column within the tileset image.
  tgd_div_pipe #(.DW(29), .VW(13), .SW(SIDE_W)) u_div_idx (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (da_vld),
    .in_dividend (da_side[28:0]),
    .in_divisor  (da_quo),
    .in_side     (db_in_sd),
    .out_vld     (db_vld),
    .out_quo     (db_quo),
    .out_rem     (db_rem),
    .out_side    (db_side)
  );

  always_comb begin
    db_sd   = tgd_pkg::side_t'(db_side);
    sx_prod = db_rem * db_sd.tw;
    sy_prod = db_quo * db_sd.th;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      m_vld_r     <= db_vld;
      out_valid_r <= m_vld_r;
    end
    m_side_r <= db_sd;
    m_sx_r   <= sx_prod[12:0];
    m_sy_r   <= (sy_prod > 39'd65535) ? 16'hFFFF : sy_prod[15:0];

    out_data_r.status       <= m_side_r.status;
    out_data_r.tileset_slot <= m_side_r.slot;
    out_data_r.src_x        <= (m_side_r.status == tgd_pkg::ST_OK) ? m_sx_r : '0;
    out_data_r.src_y        <= (m_side_r.status == tgd_pkg::ST_OK) ? m_sy_r : '0;
    out_data_r.frame_width  <= m_side_r.tw;
    out_data_r.frame_height <= m_side_r.th;
    out_data_r.render_x     <= m_side_r.render_x;
    out_data_r.render_y     <= m_side_r.render_y;
    out_data_r.flip_h       <= m_side_r.flip_h;
    out_data_r.flip_v       <= m_side_r.flip_v;
    out_data_r.flip_d       <= m_side_r.flip_d;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_src_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != tgd_pkg::ST_OK |-> out_data.src_x == '0 &&
    out_data.src_y == '0)
    else $error("source position given on a failed decode");

  a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == tgd_pkg::ST_LOADED |->
    out_data.render_x == '0 && out_data.frame_width == '0 && !out_data.flip_h)
    else $error("load result carries decode fields");

  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == tgd_pkg::ST_EMPTY |->
    !out_data.flip_h && !out_data.flip_v && !out_data.flip_d && out_data.tileset_slot == '0)
    else $error("empty tile result not cleared");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && in_r.cmd == tgd_pkg::CMD_LOAD && in_r.entry_index == 2'd0 |=> ent_vld_r[0])
    else $error("table entry not marked valid after load");

endmodule
